// ----- rtl/core/fpd_pkg.sv -----
// Shared types, constants and helpers of the flight phase detector.
// Used by every module under rtl/core; depends on nothing else.
package fpd_pkg;

  localparam int WINDOW_SIZE = 8;
  localparam int ADDR_W      = $clog2(WINDOW_SIZE);
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(WINDOW_SIZE - 1);

  localparam int ALT_W     = 24;
  localparam int BASE_W    = 25;
  localparam int SUM_W     = BASE_W + 1;
  localparam int THR_W     = 23;
  localparam int CMD_W     = 2;
  localparam int KIND_W    = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic signed [ALT_W-1:0] ALT_MIN = {1'b1, {(ALT_W-1){1'b0}}};

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_SHORT  = 2'd1,
    CMD_LONG   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    PH_READY     = 2'd0,
    PH_FLYING    = 2'd1,
    PH_FALLING   = 2'd2,
    PH_RECOVERED = 2'd3
  } phase_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_STATUS     = 3'd0,
    KIND_ALT_LOG    = 3'd1,
    KIND_APOGEE_LOG = 3'd2,
    KIND_REPORT     = 3'd3,
    KIND_ERASE      = 3'd4
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIFTOFF  = 2'd0,
    CFG_FALL     = 2'd1,
    CFG_RECOVERY = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_LOAD  = 3'd1,
    ST_EVAL  = 3'd2,
    ST_EMIT  = 3'd3,
    ST_SW_RD = 3'd4,
    ST_SW_WR = 3'd5
  } seq_state_e;

  typedef struct packed {
    logic [THR_W-1:0] liftoff;
    logic [THR_W-1:0] fall;
    logic [THR_W-1:0] recovery;
  } cfg_t;

  typedef struct packed {
    logic                    we;
    logic [ADDR_W-1:0]       waddr;
    logic signed [ALT_W-1:0] wdata;
    logic                    re;
    logic [ADDR_W-1:0]       raddr;
    logic                    clear;
  } mem_req_t;

  typedef struct packed {
    kind_e                   kind;
    logic signed [ALT_W-1:0] value;
    phase_e                  phase;
    logic                    last;
  } out_word_t;

  // Clamp a wide sum into the altitude range.
  function automatic logic signed [ALT_W-1:0] sat_alt(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-ALT_W:0] hi;
    hi = v[SUM_W-1:ALT_W-1];
    if (&hi || ~|hi) return v[ALT_W-1:0];
    else if (v[SUM_W-1]) return {1'b1, {(ALT_W-1){1'b0}}};
    else return {1'b0, {(ALT_W-1){1'b1}}};
  endfunction

  // Clamp a wide sum into the baseline range.
  function automatic logic signed [BASE_W-1:0] sat_base(input logic signed [SUM_W-1:0] v);
    logic [1:0] hi;
    hi = v[SUM_W-1:BASE_W-1];
    if (&hi || ~|hi) return v[BASE_W-1:0];
    else if (v[SUM_W-1]) return {1'b1, {(BASE_W-1){1'b0}}};
    else return {1'b0, {(BASE_W-1){1'b1}}};
  endfunction

  // Magnitude of a - b; always fits one bit above the altitude width.
  function automatic logic [ALT_W:0] abs_diff(input logic signed [ALT_W-1:0] a,
                                              input logic signed [ALT_W-1:0] b);
    logic [ALT_W:0] d;
    d = {a[ALT_W-1], a} - {b[ALT_W-1], b};
    if (d[ALT_W]) return ~d + 1'b1;
    else return d;
  endfunction

  function automatic logic [ADDR_W-1:0] next_addr(input logic [ADDR_W-1:0] a);
    if (a == LAST_IDX) return '0;
    else return a + 1'b1;
  endfunction

endpackage

// ----- rtl/core/flight_phase_detector_core.sv -----
// Top level of the flight phase detector: config registers and the datapath modules.
// Instantiates fpd_seq, fpd_window_mem and fpd_out_buf; uses fpd_pkg.
//
// One word in per command; the window of recent relative altitudes sits in a RAM
// with registered read, walked by the sequencer. An input word is taken only when the
// sequencer is idle. A button word or an ignored sample passes through load and emit,
// an ordinary sample through load, evaluate and emit (plus an apogee log when the fall
// from apogee is seen), and a liftoff sample through a sweep that reads, rebases and
// writes back each window entry in turn through the RAM, logging each as it goes; the
// sweep and emit wait while the output register is full. The sequencer takes the next
// word while a result still waits in the output register.
// Erase needs no clearing pass: per-entry valid bits zero the window at once.
// Config writes are always accepted and should be made only while the block is idle.
module flight_phase_detector_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [fpd_pkg::CMD_W-1:0]            command_i,
  input  logic signed [fpd_pkg::ALT_W-1:0]     raw_altitude_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [fpd_pkg::KIND_W-1:0]           record_kind_o,
  output logic signed [fpd_pkg::ALT_W-1:0]     value_o,
  output logic [1:0]                           phase_o,
  output logic                                 last_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [fpd_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [fpd_pkg::THR_W-1:0]            cfg_data_i
);
  import fpd_pkg::*;

  cfg_t                    cfg_q;
  mem_req_t                mem_req;
  logic signed [ALT_W-1:0] mem_rd;
  logic                    push;
  out_word_t               push_word;
  out_word_t               out_word;
  logic                    out_free;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.liftoff  <= THR_W'(100);
      cfg_q.fall     <= THR_W'(50);
      cfg_q.recovery <= THR_W'(20);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_LIFTOFF:  cfg_q.liftoff  <= cfg_data_i;
        CFG_FALL:     cfg_q.fall     <= cfg_data_i;
        CFG_RECOVERY: cfg_q.recovery <= cfg_data_i;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  fpd_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .raw_altitude_i (raw_altitude_i),
    .cfg_i          (cfg_q),
    .mem_req_o      (mem_req),
    .mem_rd_i       (mem_rd),
    .push_o         (push),
    .word_o         (push_word),
    .out_free_i     (out_free)
  );

  fpd_window_mem u_window_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (mem_rd)
  );

  fpd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .word_i      (push_word),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .word_o      (out_word)
  );

  assign record_kind_o = out_word.kind;
  assign value_o       = out_word.value;
  assign phase_o       = out_word.phase;
  assign last_o        = out_word.last;

endmodule

// ----- rtl/core/fpd_window_mem.sv -----
// Altitude window storage: synchronous RAM with registered read.
// Per-entry valid bits make unwritten or erased entries read as zero. Uses fpd_pkg.
module fpd_window_mem (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fpd_pkg::mem_req_t               req_i,
  output logic signed [fpd_pkg::ALT_W-1:0] rd_data_o
);
  import fpd_pkg::*;

  logic signed [ALT_W-1:0] mem [WINDOW_SIZE];
  logic [WINDOW_SIZE-1:0]  valid_q;
  logic signed [ALT_W-1:0] rd_data_q;
  logic                    rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_data_q <= mem[req_i.raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.clear) begin
        valid_q <= '0;
      end else if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rd_valid_q <= valid_q[req_i.raddr];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

// ----- rtl/core/fpd_out_buf.sv -----
// Output register between the sequencer and the result channel.
// Takes a new word whenever it is empty or its word is taken. Uses fpd_pkg.
module fpd_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  fpd_pkg::out_word_t word_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output fpd_pkg::out_word_t word_o
);
  import fpd_pkg::*;

  logic      valid_q;
  out_word_t word_q;

  assign free_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      word_q <= word_i;
    end
  end

  assign out_valid_o = valid_q;
  assign word_o      = word_q;

endmodule

// ----- rtl/core/fpd_seq.sv -----
// Phase sequencer: read-modify-write of the window RAM, baseline, apogee and phase.
// Drives fpd_window_mem and fpd_out_buf through structs from fpd_pkg.
module fpd_seq (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [fpd_pkg::CMD_W-1:0]        command_i,
  input  logic signed [fpd_pkg::ALT_W-1:0] raw_altitude_i,
  input  fpd_pkg::cfg_t                    cfg_i,
  output fpd_pkg::mem_req_t                mem_req_o,
  input  logic signed [fpd_pkg::ALT_W-1:0] mem_rd_i,
  output logic                             push_o,
  output fpd_pkg::out_word_t               word_o,
  input  logic                             out_free_i
);
  import fpd_pkg::*;

  seq_state_e               state_q, state_d;
  phase_e                   phase_q, phase_d;
  logic signed [BASE_W-1:0] baseline_q, baseline_d;
  logic signed [ALT_W-1:0]  apogee_q, apogee_d;
  logic [ADDR_W-1:0]        wp_q, wp_d;
  logic [ADDR_W-1:0]        sw_addr_q, sw_addr_d;
  logic [ADDR_W-1:0]        sw_cnt_q, sw_cnt_d;
  logic                     more_q, more_d;
  logic [CMD_W-1:0]         cmd_q;
  logic signed [ALT_W-1:0]  raw_q;
  logic signed [ALT_W-1:0]  newest_q, newest_d;
  logic signed [ALT_W-1:0]  old0_q, old0_d;
  kind_e                    pend_kind_q, pend_kind_d;
  logic signed [ALT_W-1:0]  pend_value_q, pend_value_d;
  logic                     pend_last_q, pend_last_d;

  logic                     accept;
  logic                     is_sample;
  logic signed [SUM_W-1:0]  rel_sum;
  logic signed [ALT_W-1:0]  rel;
  logic signed [SUM_W-1:0]  base_sum;
  logic [ALT_W:0]           span;
  logic                     liftoff_hit;
  logic                     recover_hit;
  logic signed [ALT_W-1:0]  apo_new;
  logic [ALT_W:0]           fall_gap;
  logic                     fall_hit;
  logic signed [SUM_W-1:0]  reb_sum;
  logic signed [ALT_W-1:0]  rebased;
  logic                     sw_last;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign is_sample  = (cmd_q == CMD_SAMPLE) && (phase_q != PH_RECOVERED);

  // Datapath terms used by both the next-state and the output logic.
  assign rel_sum     = {{(SUM_W-ALT_W){raw_q[ALT_W-1]}}, raw_q}
                     - {{(SUM_W-BASE_W){baseline_q[BASE_W-1]}}, baseline_q};
  assign rel         = sat_alt(rel_sum);
  assign base_sum    = {{(SUM_W-BASE_W){baseline_q[BASE_W-1]}}, baseline_q}
                     + {{(SUM_W-ALT_W){mem_rd_i[ALT_W-1]}}, mem_rd_i};
  assign span        = abs_diff(newest_q, mem_rd_i);
  assign liftoff_hit = span > {2'b00, cfg_i.liftoff};
  assign recover_hit = span < {2'b00, cfg_i.recovery};
  assign apo_new     = (newest_q > apogee_q) ? newest_q : apogee_q;
  assign fall_gap    = {apo_new[ALT_W-1], apo_new} - {newest_q[ALT_W-1], newest_q};
  assign fall_hit    = fall_gap > {2'b00, cfg_i.fall};
  assign reb_sum     = {{(SUM_W-ALT_W){mem_rd_i[ALT_W-1]}}, mem_rd_i}
                     - {{(SUM_W-ALT_W){old0_q[ALT_W-1]}}, old0_q};
  assign rebased     = sat_alt(reb_sum);
  assign sw_last     = (sw_cnt_q == LAST_IDX);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        state_d = is_sample ? ST_EVAL : ST_EMIT;
      end
      ST_EVAL: begin
        if (phase_q == PH_READY && liftoff_hit) state_d = ST_SW_RD;
        else state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free_i && !more_q) state_d = ST_IDLE;
      end
      ST_SW_RD: begin
        state_d = ST_SW_WR;
      end
      ST_SW_WR: begin
        if (out_free_i) state_d = sw_last ? ST_IDLE : ST_SW_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and register updates
  always_comb begin
    mem_req_o    = '0;
    push_o       = 1'b0;
    word_o       = '0;
    phase_d      = phase_q;
    baseline_d   = baseline_q;
    apogee_d     = apogee_q;
    wp_d         = wp_q;
    sw_addr_d    = sw_addr_q;
    sw_cnt_d     = sw_cnt_q;
    more_d       = more_q;
    newest_d     = newest_q;
    old0_d       = old0_q;
    pend_kind_d  = pend_kind_q;
    pend_value_d = pend_value_q;
    pend_last_d  = pend_last_q;
    case (state_q)
      ST_LOAD: begin
        pend_last_d  = 1'b1;
        pend_value_d = '0;
        pend_kind_d  = KIND_STATUS;
        if (is_sample) begin
          // shift in: overwrite the oldest slot, fetch the next oldest
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = wp_q;
          mem_req_o.wdata = rel;
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = next_addr(wp_q);
          wp_d            = next_addr(wp_q);
          newest_d        = rel;
        end else if (phase_q == PH_RECOVERED) begin
          case (cmd_q)
            CMD_SHORT: begin
              pend_kind_d  = KIND_REPORT;
              pend_value_d = apogee_q;
            end
            CMD_LONG: begin
              pend_kind_d     = KIND_ERASE;
              mem_req_o.clear = 1'b1;
              apogee_d        = '0;
              phase_d         = PH_READY;
            end
            default: pend_kind_d = KIND_STATUS;
          endcase
        end
      end
      ST_EVAL: begin
        pend_last_d  = 1'b1;
        pend_kind_d  = KIND_ALT_LOG;
        pend_value_d = newest_q;
        case (phase_q)
          PH_READY: begin
            if (liftoff_hit) begin
              baseline_d = sat_base(base_sum);
              old0_d     = mem_rd_i;
              apogee_d   = ALT_MIN;
              phase_d    = PH_FLYING;
              sw_addr_d  = wp_q;
              sw_cnt_d   = '0;
            end else begin
              pend_kind_d  = KIND_STATUS;
              pend_value_d = '0;
            end
          end
          PH_FLYING: begin
            apogee_d    = apo_new;
            pend_last_d = !fall_hit;
            more_d      = fall_hit;
            if (fall_hit) phase_d = PH_FALLING;
          end
          PH_FALLING: begin
            if (recover_hit) phase_d = PH_RECOVERED;
          end
          default: begin
            pend_kind_d  = KIND_STATUS;
            pend_value_d = '0;
          end
        endcase
      end
      ST_EMIT: begin
        if (out_free_i) begin
          push_o       = 1'b1;
          word_o.kind  = pend_kind_q;
          word_o.value = pend_value_q;
          word_o.phase = phase_q;
          word_o.last  = pend_last_q;
          if (more_q) begin
            // queue the apogee log behind the altitude log
            pend_kind_d  = KIND_APOGEE_LOG;
            pend_value_d = apogee_q;
            pend_last_d  = 1'b1;
            more_d       = 1'b0;
          end
        end
      end
      ST_SW_RD: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = sw_addr_q;
      end
      ST_SW_WR: begin
        // hold the fetched entry until the output register frees up
        if (out_free_i) begin
          push_o          = 1'b1;
          word_o.kind     = KIND_ALT_LOG;
          word_o.value    = rebased;
          word_o.phase    = phase_q;
          word_o.last     = sw_last;
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = sw_addr_q;
          mem_req_o.wdata = rebased;
          if (rebased > apogee_q) apogee_d = rebased;
          sw_addr_d = next_addr(sw_addr_q);
          sw_cnt_d  = sw_cnt_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      phase_q    <= PH_READY;
      baseline_q <= '0;
      apogee_q   <= '0;
      wp_q       <= '0;
      sw_addr_q  <= '0;
      sw_cnt_q   <= '0;
      more_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      baseline_q <= baseline_d;
      apogee_q   <= apogee_d;
      wp_q       <= wp_d;
      sw_addr_q  <= sw_addr_d;
      sw_cnt_q   <= sw_cnt_d;
      more_q     <= more_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= command_i;
      raw_q <= raw_altitude_i;
    end
    newest_q     <= newest_d;
    old0_q       <= old0_d;
    pend_kind_q  <= pend_kind_d;
    pend_value_q <= pend_value_d;
    pend_last_q  <= pend_last_d;
  end

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> out_free_i)
    else $error("result pushed into a full output register");

  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_req_o.we && mem_req_o.re) |-> (mem_req_o.waddr != mem_req_o.raddr))
    else $error("window read and write hit the same entry");

  a_recover_from_falling: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_RECOVERED && $past(phase_q) != PH_RECOVERED)
      |-> ($past(phase_q) == PH_FALLING))
    else $error("recovered phase entered from a phase other than falling");

  a_sweep_ends_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SW_WR && out_free_i && sw_last) |=> (state_q == ST_IDLE))
    else $error("liftoff sweep did not finish after the last entry");

endmodule
